@@ hw/rtl/erpd_pkg.sv @@
// Shared types, constants and a helper function of the escape RLE pattern decoder.
`timescale 1ns / 1ps

package erpd_pkg;

    localparam int ROWS_PER_PATTERN = 64;
    localparam int BYTES_PER_CELL   = 4;
    localparam int CHANNEL_MAX      = 15;
    localparam int PATTERN_UNIT     = ROWS_PER_PATTERN * BYTES_PER_CELL;
    localparam int BYTES_W          = $clog2(CHANNEL_MAX * PATTERN_UNIT + 1);

    localparam int CHANNEL_W = 4;
    localparam int PATTERN_W = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_COUNT = 2'd1;

    localparam logic [7:0] ESC_BYTE = 8'hFF;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_MAG = 2'd1;
    localparam logic [1:0] ST_CLIPPED = 2'd2;

    typedef struct packed {
        logic       emit;
        logic [7:0] out_byte;
        logic [7:0] run_length;
        logic       pattern_end;
        logic       all_done;
        logic [1:0] status;
    } erpd_result_t;

    typedef struct packed {
        logic                  write;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } erpd_cfg_t;

    function automatic logic [7:0] magic_byte(input logic [1:0] pos);
        logic [7:0] b;
        unique case (pos)
            2'd0: b = 8'h54;
            2'd1: b = 8'h54;
            2'd2: b = 8'h41;
            2'd3: b = 8'h50;
        endcase
        return b;
    endfunction

endpackage

@@ hw/rtl/erpd_decoder.sv @@
// Decoder state machine: magic check, escape parsing, run clipping and pattern counting.
`timescale 1ns / 1ps

module erpd_decoder
    import erpd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  erpd_cfg_t    cfg,
    input  logic         step,
    input  logic [7:0]   byte_in,
    output erpd_result_t result
);

    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_DATA,
        PH_COUNT,
        PH_VALUE,
        PH_LOCKED,
        PH_DONE
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [1:0]             magic_pos_reg, magic_pos_next;
    logic [BYTES_W-1:0]     bytes_left_reg, bytes_left_next;
    logic [PATTERN_W-1:0]   patterns_left_reg, patterns_left_next;
    logic [7:0]             pending_reg, pending_next;
    logic [CHANNEL_W-1:0]   channel_count_reg;

    logic [CHANNEL_W-1:0]   ch_eff;
    logic [BYTES_W-1:0]     bytes_load;
    logic                   do_run;
    logic [7:0]             run_byte;
    logic [7:0]             run_n;
    logic                   clip;
    logic [7:0]             n_eff;
    logic [BYTES_W-1:0]     left_after;
    logic [PATTERN_W-1:0]   patterns_dec;
    logic [PATTERN_W-1:0]   pattern_eff;

    assign ch_eff      = (channel_count_reg == '0) ? CHANNEL_W'(1) : channel_count_reg;
    assign bytes_load  = BYTES_W'(ch_eff) * BYTES_W'(PATTERN_UNIT);
    assign clip        = BYTES_W'(run_n) > bytes_left_reg;
    assign n_eff       = clip ? bytes_left_reg[7:0] : run_n;
    assign left_after  = bytes_left_reg - BYTES_W'(n_eff);
    assign patterns_dec = (patterns_left_reg != '0) ? patterns_left_reg - PATTERN_W'(1)
                                                    : patterns_left_reg;
    assign pattern_eff = (cfg.data[PATTERN_W-1:0] == '0) ? PATTERN_W'(1)
                                                         : cfg.data[PATTERN_W-1:0];

    always_comb
    begin
        phase_next         = phase_reg;
        magic_pos_next     = magic_pos_reg;
        bytes_left_next    = bytes_left_reg;
        patterns_left_next = patterns_left_reg;
        pending_next       = pending_reg;
        result             = '0;
        do_run             = 1'b0;
        run_byte           = byte_in;
        run_n              = 8'd1;

        if (step)
        begin
            unique case (phase_reg)
                PH_MAGIC:
                begin
                    if (byte_in != magic_byte(magic_pos_reg))
                    begin
                        phase_next      = PH_LOCKED;
                        result.emit     = 1'b1;
                        result.out_byte = byte_in;
                        result.status   = ST_BAD_MAG;
                    end
                    else if (magic_pos_reg != 2'd3)
                    begin
                        magic_pos_next = magic_pos_reg + 2'd1;
                    end
                    else
                    begin
                        magic_pos_next  = 2'd0;
                        bytes_left_next = bytes_load;
                        phase_next      = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    if (byte_in == ESC_BYTE)
                    begin
                        phase_next = PH_COUNT;
                    end
                    else
                    begin
                        do_run = 1'b1;
                    end
                end
                PH_COUNT:
                begin
                    if (byte_in == 8'd0)
                    begin
                        do_run   = 1'b1;
                        run_byte = ESC_BYTE;
                    end
                    else
                    begin
                        pending_next = byte_in;
                        phase_next   = PH_VALUE;
                    end
                end
                PH_VALUE:
                begin
                    pending_next = 8'd0;
                    do_run       = 1'b1;
                    run_n        = pending_reg;
                end
                PH_LOCKED, PH_DONE:
                begin
                end
                default:
                begin
                end
            endcase
        end

        if (do_run)
        begin
            bytes_left_next   = left_after;
            result.emit       = 1'b1;
            result.out_byte   = run_byte;
            result.run_length = n_eff;
            result.status     = clip ? ST_CLIPPED : ST_OK;
            if (left_after == '0)
            begin
                result.pattern_end = 1'b1;
                patterns_left_next = patterns_dec;
                if (patterns_dec == '0)
                begin
                    result.all_done = 1'b1;
                    phase_next      = PH_DONE;
                end
                else
                begin
                    phase_next     = PH_MAGIC;
                    magic_pos_next = 2'd0;
                end
            end
            else
            begin
                phase_next = PH_DATA;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_MAGIC;
            magic_pos_reg     <= 2'd0;
            bytes_left_reg    <= '0;
            patterns_left_reg <= PATTERN_W'(1);
            pending_reg       <= 8'd0;
            channel_count_reg <= CHANNEL_W'(4);
        end
        else
        begin
            phase_reg      <= phase_next;
            magic_pos_reg  <= magic_pos_next;
            bytes_left_reg <= bytes_left_next;
            pending_reg    <= pending_next;
            if (cfg.write && cfg.index == REG_PATTERN_COUNT)
            begin
                patterns_left_reg <= pattern_eff;
            end
            else
            begin
                patterns_left_reg <= patterns_left_next;
            end
            if (cfg.write && cfg.index == REG_CHANNEL_COUNT)
            begin
                channel_count_reg <= cfg.data[CHANNEL_W-1:0];
            end
        end
    end

endmodule

@@ hw/rtl/escape_rle_pattern_decoder_unit.sv @@
// Top level: input register, decoder and result register with valid/ready handshakes.
// An accepted input beat passes from the input register through the decoder into the result register.
// Throughput: one input beat per cycle while the output is not stalled; bytes that only open a code give no result.
// The input register advances whenever the result register is empty or being drained.
// Reset clears the valid flags of both registers, reloads one pattern of four channels and awaits magic.
`timescale 1ns / 1ps

module escape_rle_pattern_decoder_unit
    import erpd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            in_byte,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_byte,
    output logic [7:0]            run_length,
    output logic                  pattern_end,
    output logic                  all_done,
    output logic [1:0]            status
);

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         out_valid_reg;
    erpd_result_t res_reg;
    erpd_result_t res;
    erpd_cfg_t    cfg;
    logic         advance;

    assign cfg.write = cfg_write;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    erpd_decoder u_decoder (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .step    (advance),
        .byte_in (in_byte_reg),
        .result  (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= res.emit;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= in_byte;
        end
        if (advance && res.emit)
        begin
            res_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = res_reg.out_byte;
    assign run_length  = res_reg.run_length;
    assign pattern_end = res_reg.pattern_end;
    assign all_done    = res_reg.all_done;
    assign status      = res_reg.status;

endmodule
